// ----- src/assert_macros.svh -----
// Assertion macros used by ray_sphere_intersect_core.
// Users must have clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/rsi_pkg.sv -----
`timescale 1ns / 1ps
// Ray/sphere intersect package: formats, stage payload structs, register codes,
// square root and CORDIC step functions. No dependencies.
package rsi_pkg;

   localparam int COORD_FRAC_BITS = 16;
   localparam int DIR_FRAC        = 15;
   localparam int NORM_SHIFT      = 2 * COORD_FRAC_BITS - DIR_FRAC;
   localparam int DISC_W          = 70;
   localparam int DISC_STEPS      = DISC_W / 2;
   localparam int SQ_ROOT_W       = 35;
   localparam int SQ_REM_W        = 37;
   localparam int WSQ_W           = 32;
   localparam int WSQ_STEPS       = WSQ_W / 2;
   localparam int ANGLE_STEPS     = 18;
   localparam int CW              = 34;
   localparam int CORDIC_SCALE    = 14;

   typedef enum logic [2:0] {
      REG_CENTER_X   = 3'd0,
      REG_CENTER_Y   = 3'd1,
      REG_CENTER_Z   = 3'd2,
      REG_RADIUS     = 3'd3,
      REG_INV_RADIUS = 3'd4,
      REG_MATERIAL   = 3'd5
   } reg_idx_type;

   typedef struct packed {
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] center_z;
      logic [30:0]        radius;
      logic [30:0]        inv_radius;
      logic [15:0]        material_id;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic signed [16:0] dir_x;
      logic signed [16:0] dir_y;
      logic signed [16:0] dir_z;
      logic signed [31:0] t_min;
      logic signed [31:0] t_max;
   } ray_type;

   typedef struct packed {
      ray_type            ray;
      logic signed [35:0] h;
      logic               pos;
   } disc_type;

   typedef struct packed {
      ray_type            ray;
      logic               hit;
      logic signed [31:0] distance;
   } sel_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] distance;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic signed [16:0] normal_x;
      logic signed [16:0] normal_y;
      logic signed [16:0] normal_z;
      logic               front_face;
   } shd_type;

   typedef struct packed {
      shd_type     shd;
      logic [16:0] tex_u;
      logic [16:0] tex_v;
   } res_type;

   typedef struct packed {
      logic [SQ_REM_W-1:0]  rem;
      logic [SQ_ROOT_W-1:0] root;
   } sq_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic [31:0]          ang;
      logic                 zero;
   } cor_type;

   function automatic sq_type sqrt_step(sq_type cur, logic [1:0] pair);
      logic [SQ_REM_W+1:0] r2;
      logic [SQ_REM_W+1:0] trial;
      sq_type              nxt;
      r2    = {cur.rem, pair};
      trial = {2'b00, cur.root, 2'b01};
      if (r2 >= trial) begin
         nxt.rem  = SQ_REM_W'(r2 - trial);
         nxt.root = {cur.root[SQ_ROOT_W-2:0], 1'b1};
      end else begin
         nxt.rem  = SQ_REM_W'(r2);
         nxt.root = {cur.root[SQ_ROOT_W-2:0], 1'b0};
      end
      return nxt;
   endfunction

   // one turn is 2^32
   function automatic logic [31:0] atan_angle(logic [4:0] i);
      logic [31:0] a;
      unique case (i)
         5'd0:  a = 32'd536870912;
         5'd1:  a = 32'd316933406;
         5'd2:  a = 32'd167458907;
         5'd3:  a = 32'd85004756;
         5'd4:  a = 32'd42667331;
         5'd5:  a = 32'd21354465;
         5'd6:  a = 32'd10680862;
         5'd7:  a = 32'd5340245;
         5'd8:  a = 32'd2670163;
         5'd9:  a = 32'd1335087;
         5'd10: a = 32'd667544;
         5'd11: a = 32'd333772;
         5'd12: a = 32'd166886;
         5'd13: a = 32'd83443;
         5'd14: a = 32'd41722;
         5'd15: a = 32'd20861;
         5'd16: a = 32'd10430;
         5'd17: a = 32'd5215;
         default: a = 32'd0;
      endcase
      return a;
   endfunction

   function automatic cor_type cordic_init(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
      cor_type c;
      c.zero = (x == 0) && (y == 0);
      if (x < 0) begin
         c.x   = -x;
         c.y   = -y;
         c.ang = 32'h8000_0000;
      end else begin
         c.x   = x;
         c.y   = y;
         c.ang = 32'd0;
      end
      return c;
   endfunction

   function automatic cor_type cordic_step(cor_type c, logic [4:0] i);
      logic signed [CW-1:0] xs;
      logic signed [CW-1:0] ys;
      cor_type              n;
      xs = c.x >>> i;
      ys = c.y >>> i;
      n  = c;
      if (c.y > 0) begin
         n.x   = c.x + ys;
         n.y   = c.y - xs;
         n.ang = c.ang + atan_angle(i);
      end else begin
         n.x   = c.x - ys;
         n.y   = c.y + xs;
         n.ang = c.ang - atan_angle(i);
      end
      return n;
   endfunction

   function automatic logic signed [31:0] sat32(logic signed [35:0] v);
      logic signed [31:0] r;
      if (v > 36'sd2147483647)       r = 32'sh7FFF_FFFF;
      else if (v < -36'sd2147483648) r = 32'sh8000_0000;
      else                           r = 32'(v);
      return r;
   endfunction

endpackage

// ----- src/rsi_disc.sv -----
`timescale 1ns / 1ps
// Front end: offset to center, dot with direction, squares and discriminant.
// Five register stages. Uses rsi_pkg.
module rsi_disc (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  rsi_pkg::ray_type            in_ray,
   input  rsi_pkg::cfg_type            cfg,
   output logic                        out_valid,
   output rsi_pkg::disc_type           out_disc,
   output logic [rsi_pkg::DISC_W-1:0]  out_rad
);
   import rsi_pkg::*;

   localparam logic signed [51:0] H_RND = 52'sd1 <<< (DIR_FRAC - 1);

   logic [4:0]         v_ff;
   ray_type            ray1_ff, ray2_ff, ray3_ff, ray4_ff;
   logic signed [32:0] oc_in [3];
   logic signed [32:0] oc1_ff [3];
   logic signed [16:0] dir1 [3];
   logic [32:0]        am [3];
   logic signed [49:0] pd_in [3];
   logic signed [49:0] pd2_ff [3];
   logic [65:0]        sq_in [3];
   logic [65:0]        sq2_ff [3];
   logic signed [51:0] hs;
   logic signed [35:0] h_in, h3_ff, h4_ff;
   logic [67:0]        b_in, b3_ff, b4_ff;
   logic [34:0]        hm;
   logic [69:0]        hh_in, hh4_ff;
   logic [61:0]        rr_in, rr4_ff;
   logic [70:0]        a_sum, d_sum;
   disc_type           disc_in, disc_ff;
   logic [DISC_W-1:0]  rad_in, rad_ff;

   always_comb begin
      oc_in[0] = 33'(cfg.center_x) - 33'(in_ray.origin_x);
      oc_in[1] = 33'(cfg.center_y) - 33'(in_ray.origin_y);
      oc_in[2] = 33'(cfg.center_z) - 33'(in_ray.origin_z);
      dir1[0]  = ray1_ff.dir_x;
      dir1[1]  = ray1_ff.dir_y;
      dir1[2]  = ray1_ff.dir_z;
      for (int i = 0; i < 3; i++) begin
         am[i]    = oc1_ff[i][32] ? 33'(-oc1_ff[i]) : 33'(oc1_ff[i]);
         pd_in[i] = 50'(oc1_ff[i]) * 50'(dir1[i]);
         sq_in[i] = 66'(am[i]) * 66'(am[i]);
      end
      hs    = 52'(pd2_ff[0]) + 52'(pd2_ff[1]) + 52'(pd2_ff[2]) + H_RND;
      h_in  = 36'(hs >>> DIR_FRAC);
      b_in  = 68'(sq2_ff[0]) + 68'(sq2_ff[1]) + 68'(sq2_ff[2]);
      hm    = h3_ff[35] ? 35'(-h3_ff) : 35'(h3_ff);
      hh_in = 70'(hm) * 70'(hm);
      rr_in = 62'(cfg.radius) * 62'(cfg.radius);
      a_sum = 71'(hh4_ff) + 71'(rr4_ff);
      d_sum = a_sum - 71'(b4_ff);
      disc_in.ray = ray4_ff;
      disc_in.h   = h4_ff;
      disc_in.pos = a_sum > 71'(b4_ff);
      rad_in      = d_sum[DISC_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ray1_ff <= in_ray;
         ray2_ff <= ray1_ff;
         ray3_ff <= ray2_ff;
         ray4_ff <= ray3_ff;
         oc1_ff  <= oc_in;
         pd2_ff  <= pd_in;
         sq2_ff  <= sq_in;
         h3_ff   <= h_in;
         b3_ff   <= b_in;
         h4_ff   <= h3_ff;
         b4_ff   <= b3_ff;
         hh4_ff  <= hh_in;
         rr4_ff  <= rr_in;
         disc_ff <= disc_in;
         rad_ff  <= rad_in;
      end
   end

   assign out_valid = v_ff[4];
   assign out_disc  = disc_ff;
   assign out_rad   = rad_ff;

endmodule

// ----- src/rsi_root.sv -----
`timescale 1ns / 1ps
// Square root of the discriminant, one root bit per stage, then root choice
// against the distance window. Uses rsi_pkg.
module rsi_root (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  rsi_pkg::disc_type           in_disc,
   input  logic [rsi_pkg::DISC_W-1:0]  in_rad,
   output logic                        out_valid,
   output rsi_pkg::sel_type            out_sel
);
   import rsi_pkg::*;

   logic              v_st [0:DISC_STEPS];
   disc_type          d_st [0:DISC_STEPS];
   logic [DISC_W-1:0] r_st [0:DISC_STEPS];
   sq_type            s_st [0:DISC_STEPS];
   logic              v_ff [0:DISC_STEPS-1];
   disc_type          d_ff [0:DISC_STEPS-1];
   logic [DISC_W-1:0] r_ff [0:DISC_STEPS-1];
   sq_type            s_ff [0:DISC_STEPS-1];

   logic signed [37:0] sx, r0, r1, lo, hi;
   logic               in0, in1;
   sel_type            sel_in, sel_ff;
   logic               vo_ff;

   assign v_st[0] = in_valid;
   assign d_st[0] = in_disc;
   assign r_st[0] = in_rad;
   assign s_st[0] = '0;

   for (genvar k = 0; k < DISC_STEPS; k++) begin : g_step
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_st[k];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            d_ff[k] <= d_st[k];
            r_ff[k] <= r_st[k];
            s_ff[k] <= sqrt_step(s_st[k], r_st[k][DISC_W-1-2*k -: 2]);
         end
      end
      assign v_st[k+1] = v_ff[k];
      assign d_st[k+1] = d_ff[k];
      assign r_st[k+1] = r_ff[k];
      assign s_st[k+1] = s_ff[k];
   end

   always_comb begin
      sx  = 38'(s_st[DISC_STEPS].root);
      r0  = 38'(d_st[DISC_STEPS].h) - sx;
      r1  = 38'(d_st[DISC_STEPS].h) + sx;
      lo  = 38'(d_st[DISC_STEPS].ray.t_min);
      hi  = 38'(d_st[DISC_STEPS].ray.t_max);
      in0 = (r0 >= lo) && (r0 <= hi);
      in1 = (r1 >= lo) && (r1 <= hi);
      sel_in.ray      = d_st[DISC_STEPS].ray;
      sel_in.hit      = d_st[DISC_STEPS].pos && (in0 || in1);
      sel_in.distance = in0 ? 32'(r0) : 32'(r1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (en) begin
         vo_ff <= v_st[DISC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sel_ff <= sel_in;
      end
   end

   assign out_valid = vo_ff;
   assign out_sel   = sel_ff;

endmodule

// ----- src/rsi_shade.sv -----
`timescale 1ns / 1ps
// Hit point, scaled outward normal (flipped on back faces) and face orientation, five stages.
// Uses rsi_pkg.
module rsi_shade (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  rsi_pkg::sel_type  in_sel,
   input  rsi_pkg::cfg_type  cfg,
   output logic              out_valid,
   output rsi_pkg::shd_type  out_shd
);
   import rsi_pkg::*;

   localparam logic signed [49:0] P_RND = 50'sd1 <<< (DIR_FRAC - 1);
   localparam logic [64:0]        N_RND = 65'd1 << (NORM_SHIFT - 1);

   logic [4:0]         v_ff;
   sel_type            sel1_ff, sel2_ff, sel3_ff, sel4_ff;
   logic signed [16:0] dir0 [3];
   logic signed [31:0] org1 [3];
   logic signed [31:0] cen [3];
   logic signed [48:0] pr_in [3];
   logic signed [48:0] pr1_ff [3];
   logic signed [49:0] q [3];
   logic signed [34:0] sh [3];
   logic signed [31:0] p_in [3];
   logic signed [31:0] p2_ff [3];
   logic signed [31:0] p3_ff [3];
   logic signed [31:0] p4_ff [3];
   logic signed [32:0] dd [3];
   logic               neg_in [3];
   logic               neg3_ff [3];
   logic [32:0]        md_in [3];
   logic [32:0]        md3_ff [3];
   logic [64:0]        pw [3];
   logic [47:0]        m [3];
   logic signed [16:0] mc [3];
   logic signed [16:0] n_in [3];
   logic signed [16:0] n4_ff [3];
   logic signed [16:0] dir4 [3];
   logic signed [35:0] dot;
   logic               front;
   shd_type            shd_in, shd_ff;

   always_comb begin
      dir0[0] = in_sel.ray.dir_x;
      dir0[1] = in_sel.ray.dir_y;
      dir0[2] = in_sel.ray.dir_z;
      org1[0] = sel1_ff.ray.origin_x;
      org1[1] = sel1_ff.ray.origin_y;
      org1[2] = sel1_ff.ray.origin_z;
      cen[0]  = cfg.center_x;
      cen[1]  = cfg.center_y;
      cen[2]  = cfg.center_z;
      dir4[0] = sel4_ff.ray.dir_x;
      dir4[1] = sel4_ff.ray.dir_y;
      dir4[2] = sel4_ff.ray.dir_z;
      for (int i = 0; i < 3; i++) begin
         pr_in[i]  = 49'(in_sel.distance) * 49'(dir0[i]);
         q[i]      = 50'(pr1_ff[i]) + P_RND;
         sh[i]     = 35'(q[i] >>> DIR_FRAC);
         p_in[i]   = sat32(36'(org1[i]) + 36'(sh[i]));
         dd[i]     = 33'(p2_ff[i]) - 33'(cen[i]);
         neg_in[i] = dd[i][32];
         md_in[i]  = dd[i][32] ? 33'(-dd[i]) : 33'(dd[i]);
         pw[i]     = 65'(md3_ff[i]) * 65'(cfg.inv_radius) + N_RND;
         m[i]      = 48'(pw[i] >> NORM_SHIFT);
         mc[i]     = (m[i] > 48'd32768) ? 17'sd32768 : 17'(m[i]);
         n_in[i]   = neg3_ff[i] ? -mc[i] : mc[i];
      end
      dot = 36'(dir4[0]) * 36'(n4_ff[0]) + 36'(dir4[1]) * 36'(n4_ff[1])
          + 36'(dir4[2]) * 36'(n4_ff[2]);
      front = dot < 0;
      shd_in.hit        = sel4_ff.hit;
      shd_in.distance   = sel4_ff.distance;
      shd_in.point_x    = p4_ff[0];
      shd_in.point_y    = p4_ff[1];
      shd_in.point_z    = p4_ff[2];
      shd_in.normal_x   = front ? n4_ff[0] : -n4_ff[0];
      shd_in.normal_y   = front ? n4_ff[1] : -n4_ff[1];
      shd_in.normal_z   = front ? n4_ff[2] : -n4_ff[2];
      shd_in.front_face = front;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sel1_ff <= in_sel;
         sel2_ff <= sel1_ff;
         sel3_ff <= sel2_ff;
         sel4_ff <= sel3_ff;
         pr1_ff  <= pr_in;
         p2_ff   <= p_in;
         p3_ff   <= p2_ff;
         p4_ff   <= p3_ff;
         neg3_ff <= neg_in;
         md3_ff  <= md_in;
         n4_ff   <= n_in;
         shd_ff  <= shd_in;
      end
   end

   assign out_valid = v_ff[4];
   assign out_shd   = shd_ff;

endmodule

// ----- src/rsi_uv.sv -----
`timescale 1ns / 1ps
// Spherical u,v: sqrt of 1 - ny^2, then two CORDIC atan2 pipelines in lockstep.
// 37 stages. Uses rsi_pkg.
module rsi_uv (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  rsi_pkg::shd_type  in_shd,
   output logic              out_valid,
   output rsi_pkg::res_type  out_res
);
   import rsi_pkg::*;

   localparam logic signed [34:0] ONE_SQ = 35'sd1 <<< 30;
   localparam logic signed [33:0] TURN   = 34'sd1 <<< 32;
   localparam logic signed [33:0] QTR    = 34'sd1 <<< 30;
   localparam logic signed [33:0] HALF   = 34'sd1 <<< 31;
   localparam logic signed [33:0] V_RND  = 34'sd1 <<< 14;

   logic signed [33:0] ny2;
   logic signed [34:0] w;
   logic [WSQ_W-1:0]   wsq_in;
   logic               v0_ff;
   shd_type            shd0_ff;
   logic [WSQ_W-1:0]   wsq0_ff;

   logic              sv_st [0:WSQ_STEPS];
   shd_type           sd_st [0:WSQ_STEPS];
   logic [WSQ_W-1:0]  sr_st [0:WSQ_STEPS];
   sq_type            ss_st [0:WSQ_STEPS];
   logic              sv_ff [0:WSQ_STEPS-1];
   shd_type           sd_ff [0:WSQ_STEPS-1];
   logic [WSQ_W-1:0]  sr_ff [0:WSQ_STEPS-1];
   sq_type            ss_ff [0:WSQ_STEPS-1];

   logic signed [CW-1:0] avx, xu, yu, xv, yv;
   logic                 vc_ff;
   shd_type              shdc_ff;
   cor_type              cu_ff, cv_ff;

   logic    cv_st [0:ANGLE_STEPS];
   shd_type cd_st [0:ANGLE_STEPS];
   cor_type uu_st [0:ANGLE_STEPS];
   cor_type vv_st [0:ANGLE_STEPS];
   logic    kv_ff [0:ANGLE_STEPS-1];
   shd_type kd_ff [0:ANGLE_STEPS-1];
   cor_type ku_ff [0:ANGLE_STEPS-1];
   cor_type kw_ff [0:ANGLE_STEPS-1];

   logic [31:0]        au, av, us;
   logic signed [33:0] sa;
   res_type            res_in, res_ff;
   logic               vo_ff;

   always_comb begin
      ny2    = 34'(in_shd.normal_y) * 34'(in_shd.normal_y);
      w      = ONE_SQ - 35'(ny2);
      wsq_in = (w < 0) ? '0 : WSQ_W'(w);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         shd0_ff <= in_shd;
         wsq0_ff <= wsq_in;
      end
   end

   assign sv_st[0] = v0_ff;
   assign sd_st[0] = shd0_ff;
   assign sr_st[0] = wsq0_ff;
   assign ss_st[0] = '0;

   for (genvar k = 0; k < WSQ_STEPS; k++) begin : g_sqrt
      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[k] <= 1'b0;
         end else if (en) begin
            sv_ff[k] <= sv_st[k];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            sd_ff[k] <= sd_st[k];
            sr_ff[k] <= sr_st[k];
            ss_ff[k] <= sqrt_step(ss_st[k], sr_st[k][WSQ_W-1-2*k -: 2]);
         end
      end
      assign sv_st[k+1] = sv_ff[k];
      assign sd_st[k+1] = sd_ff[k];
      assign sr_st[k+1] = sr_ff[k];
      assign ss_st[k+1] = ss_ff[k];
   end

   // u: atan2(-nz, nx); v: atan2(sqrt(1 - ny^2), -ny)
   always_comb begin
      avx = CW'(ss_st[WSQ_STEPS].root[WSQ_STEPS-1:0]);
      xu  = CW'(sd_st[WSQ_STEPS].normal_x) <<< CORDIC_SCALE;
      yu  = -(CW'(sd_st[WSQ_STEPS].normal_z) <<< CORDIC_SCALE);
      xv  = -(CW'(sd_st[WSQ_STEPS].normal_y) <<< CORDIC_SCALE);
      yv  = avx <<< CORDIC_SCALE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else if (en) begin
         vc_ff <= sv_st[WSQ_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         shdc_ff <= sd_st[WSQ_STEPS];
         cu_ff   <= cordic_init(xu, yu);
         cv_ff   <= cordic_init(xv, yv);
      end
   end

   assign cv_st[0] = vc_ff;
   assign cd_st[0] = shdc_ff;
   assign uu_st[0] = cu_ff;
   assign vv_st[0] = cv_ff;

   for (genvar k = 0; k < ANGLE_STEPS; k++) begin : g_cordic
      always_ff @(posedge clock) begin
         if (reset) begin
            kv_ff[k] <= 1'b0;
         end else if (en) begin
            kv_ff[k] <= cv_st[k];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            kd_ff[k] <= cd_st[k];
            ku_ff[k] <= cordic_step(uu_st[k], 5'(k));
            kw_ff[k] <= cordic_step(vv_st[k], 5'(k));
         end
      end
      assign cv_st[k+1] = kv_ff[k];
      assign cd_st[k+1] = kd_ff[k];
      assign uu_st[k+1] = ku_ff[k];
      assign vv_st[k+1] = kw_ff[k];
   end

   always_comb begin
      au = uu_st[ANGLE_STEPS].zero ? 32'd0 : uu_st[ANGLE_STEPS].ang;
      av = vv_st[ANGLE_STEPS].zero ? 32'd0 : vv_st[ANGLE_STEPS].ang;
      us = au + 32'h8000_0000;
      sa = 34'(av);
      if (av > 32'h8000_0000) sa = sa - TURN;
      if (sa < -QTR)          sa = sa + TURN;
      if (sa < 0)             sa = '0;
      if (sa > HALF)          sa = HALF;
      res_in.shd   = cd_st[ANGLE_STEPS];
      res_in.tex_u = 17'((33'(us) + 33'd32768) >> 16);
      res_in.tex_v = 17'((sa + V_RND) >>> 15);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (en) begin
         vo_ff <= cv_st[ANGLE_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign out_valid = vo_ff;
   assign out_res   = res_ff;

endmodule

// ----- src/ray_sphere_intersect_core.sv -----
`timescale 1ns / 1ps
// Ray/sphere intersect top level: register file, stream ports, pipeline chain.
// Uses rsi_pkg, rsi_disc, rsi_root, rsi_shade, rsi_uv, assert_macros.svh.
//
//   port group | dir | carries
//   req_*      | in  | one ray per beat
//   rsp_*      | out | one hit record per beat
//   csr_*      | in  | sphere registers, APB-style
//
// One ray per cycle while the pipeline is not held. The req-to-rsp_tvalid path
// is dominated by the 35-stage discriminant square root, the 16-stage
// square root for v and the 18-stage CORDIC.
// The whole pipeline holds while rsp_tvalid is high and rsp_tready low.
// Synchronous reset clears the valid bits and loads the register defaults.
`include "assert_macros.svh"
module ray_sphere_intersect_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_min, t_max
   input  logic [215:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // distance, point_x, point_y, point_z, normal_x, normal_y, normal_z,
   // front_face, tex_u, tex_v, hit_material
   output logic [231:0] rsp_tdata,
   // hit
   output logic         rsp_tuser,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import rsi_pkg::*;

   cfg_type           cfg_ff;
   logic              csr_wr;
   logic              en;
   ray_type           ray;
   logic              d_valid, r_valid, s_valid, u_valid;
   disc_type          d_disc;
   logic [DISC_W-1:0] d_rad;
   sel_type           r_sel;
   shd_type           s_shd;
   res_type           u_res;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_x    <= '0;
         cfg_ff.center_y    <= '0;
         cfg_ff.center_z    <= '0;
         cfg_ff.radius      <= 31'd65536;
         cfg_ff.inv_radius  <= 31'd65536;
         cfg_ff.material_id <= '0;
      end else if (csr_wr) begin
         unique case (csr_paddr[4:2])
            REG_CENTER_X:   cfg_ff.center_x    <= csr_pwdata;
            REG_CENTER_Y:   cfg_ff.center_y    <= csr_pwdata;
            REG_CENTER_Z:   cfg_ff.center_z    <= csr_pwdata;
            REG_RADIUS:     cfg_ff.radius      <= csr_pwdata[30:0];
            REG_INV_RADIUS: cfg_ff.inv_radius  <= csr_pwdata[30:0];
            REG_MATERIAL:   cfg_ff.material_id <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         REG_CENTER_X:   csr_prdata = cfg_ff.center_x;
         REG_CENTER_Y:   csr_prdata = cfg_ff.center_y;
         REG_CENTER_Z:   csr_prdata = cfg_ff.center_z;
         REG_RADIUS:     csr_prdata = {1'b0, cfg_ff.radius};
         REG_INV_RADIUS: csr_prdata = {1'b0, cfg_ff.inv_radius};
         REG_MATERIAL:   csr_prdata = {16'd0, cfg_ff.material_id};
         default:        csr_prdata = '0;
      endcase
   end

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   always_comb begin
      ray.origin_x = req_tdata[31:0];
      ray.origin_y = req_tdata[63:32];
      ray.origin_z = req_tdata[95:64];
      ray.dir_x    = req_tdata[112:96];
      ray.dir_y    = req_tdata[129:113];
      ray.dir_z    = req_tdata[146:130];
      ray.t_min    = req_tdata[178:147];
      ray.t_max    = req_tdata[210:179];
   end

   rsi_disc u_disc (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_ray    (ray),
      .cfg       (cfg_ff),
      .out_valid (d_valid),
      .out_disc  (d_disc),
      .out_rad   (d_rad)
   );

   rsi_root u_root (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_valid),
      .in_disc   (d_disc),
      .in_rad    (d_rad),
      .out_valid (r_valid),
      .out_sel   (r_sel)
   );

   rsi_shade u_shade (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (r_valid),
      .in_sel    (r_sel),
      .cfg       (cfg_ff),
      .out_valid (s_valid),
      .out_shd   (s_shd)
   );

   rsi_uv u_uv (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s_valid),
      .in_shd    (s_shd),
      .out_valid (u_valid),
      .out_res   (u_res)
   );

   assign rsp_tvalid = u_valid;
   assign rsp_tuser  = u_res.shd.hit;
   assign rsp_tdata  = u_res.shd.hit ?
      {2'b00, cfg_ff.material_id, u_res.tex_v, u_res.tex_u, u_res.shd.front_face,
       u_res.shd.normal_z, u_res.shd.normal_y, u_res.shd.normal_x,
       u_res.shd.point_z, u_res.shd.point_y, u_res.shd.point_x, u_res.shd.distance} : '0;

   `ASSERT_IMPL(a_idle_after_reset, $past(reset), !rsp_tvalid, "result beat right after reset")
   `ASSERT_IMPL(a_stall_blocks_req, rsp_tvalid && !rsp_tready, !req_tready, "ray taken in stall")
   `ASSERT_IMPL(a_tex_u_range, rsp_tvalid && rsp_tuser, rsp_tdata[196:180] <= 17'd65536, "tex_u range")
   `ASSERT_IMPL(a_tex_v_range, rsp_tvalid && rsp_tuser, rsp_tdata[213:197] <= 17'd65536, "tex_v range")

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Testbench for ray_sphere_intersect_core: directed rays, then random rays, most aimed
// at the configured sphere, checked beat by beat against a fixed-point hit predictor.
// Depends on rsi_pkg and the core RTL.
module tb;
   import rsi_pkg::*;

   localparam int CYCLE_LIMIT     = 600000;
   localparam int ITEMS_PER_PHASE = 460;
   localparam int TAIL_CYCLES     = 120;
   localparam int BAD_REG_IDX     = 6;
   localparam longint Q_ONE       = 65536;
   localparam longint S32_MAX     = 64'sd2147483647;
   localparam longint S32_MIN     = -64'sd2147483648;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic signed [16:0] dir_x;
      logic signed [16:0] dir_y;
      logic signed [16:0] dir_z;
      logic signed [31:0] t_min;
      logic signed [31:0] t_max;
   } ray_t;

   typedef struct packed {
      logic        hit;
      logic [31:0] distance;
      logic [31:0] px;
      logic [31:0] py;
      logic [31:0] pz;
      logic [16:0] nx;
      logic [16:0] ny;
      logic [16:0] nz;
      logic        front;
      logic [16:0] u;
      logic [16:0] v;
      logic [15:0] mat;
   } hit_rec_t;

   typedef struct {
      ray_t ray;
      bit   known_miss;
   } probe_t;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [215:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [231:0] rsp_tdata;
   logic         rsp_tuser;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [4:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   cfg_type  sph;
   hit_rec_t hits_due[$];
   hit_rec_t got_rec;
   hit_rec_t want_rec;
   int       errors;
   int       cycles;
   int       tx_gap_pct;
   int       rx_stall_pct;

   ray_sphere_intersect_core dut (.*);

   localparam bit [31:0] ATAN_TURNS[18] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10680862, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215
   };

   function automatic longint clamp32(longint v);
      return v > S32_MAX ? S32_MAX : (v < S32_MIN ? S32_MIN : v);
   endfunction

   function automatic longint floor_sqrt(logic [127:0] v);
      logic [127:0] lo, hi, mid;
      lo = 0;
      hi = 128'd1 << 37;
      while (hi - lo > 1) begin
         mid = lo + ((hi - lo) >> 1);
         if (mid * mid <= v) lo = mid;
         else hi = mid;
      end
      return longint'(lo);
   endfunction

   function automatic longint normal_axis(longint d);
      logic [127:0] p;
      longint       m;
      p = (d < 0 ? -d : d);
      p = p * sph.inv_radius + (128'd1 << (NORM_SHIFT - 1));
      p = p >> NORM_SHIFT;
      m = (p > 32768) ? 32768 : longint'(p);
      return d < 0 ? -m : m;
   endfunction

   function automatic bit [31:0] turn_atan2(longint y, longint x);
      bit [31:0] ang;
      longint    xs, ys;
      ang = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         x = -x;
         y = -y;
         ang = 32'h8000_0000;
      end
      for (int i = 0; i < 18; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            ang = ang + ATAN_TURNS[i];
         end else begin
            x = x - ys;
            y = y + xs;
            ang = ang - ATAN_TURNS[i];
         end
      end
      return ang;
   endfunction

   function automatic hit_rec_t predict_hit(ray_t r);
      hit_rec_t            o;
      longint              ox, oy, oz, dx, dy, dz, tmin, tmax, cx, cy, cz, rad;
      longint              ocx, ocy, ocz, h, s, root, px, py, pz, nx, ny, nz;
      longint              wsq, av, sa, tu;
      logic signed [127:0] hw, rw, wx, wy, wz, disc;
      bit [31:0]           ang;
      bit                  front;
      o = '0;
      ox = r.origin_x; oy = r.origin_y; oz = r.origin_z;
      dx = r.dir_x; dy = r.dir_y; dz = r.dir_z;
      tmin = r.t_min; tmax = r.t_max;
      cx = sph.center_x; cy = sph.center_y; cz = sph.center_z;
      rad = sph.radius;
      ocx = cx - ox; ocy = cy - oy; ocz = cz - oz;
      h = (ocx * dx + ocy * dy + ocz * dz + 16384) >>> DIR_FRAC;
      hw = h; rw = rad; wx = ocx; wy = ocy; wz = ocz;
      disc = hw * hw + rw * rw - (wx * wx + wy * wy + wz * wz);
      if (disc <= 0) return o;
      s = floor_sqrt(disc);
      root = h - s;
      if (root < tmin || root > tmax) begin
         root = h + s;
         if (root < tmin || root > tmax) return o;
      end
      px = clamp32(ox + ((root * dx + 16384) >>> DIR_FRAC));
      py = clamp32(oy + ((root * dy + 16384) >>> DIR_FRAC));
      pz = clamp32(oz + ((root * dz + 16384) >>> DIR_FRAC));
      nx = normal_axis(px - cx);
      ny = normal_axis(py - cy);
      nz = normal_axis(pz - cz);
      front = (dx * nx + dy * ny + dz * nz) < 0;
      if (!front) begin
         nx = -nx; ny = -ny; nz = -nz;
      end
      ang = turn_atan2(-nz * 16384, nx * 16384) + 32'h8000_0000;
      tu = ang;
      o.u = 17'((tu + 32768) >> 16);
      wsq = (64'sd1 << 30) - ny * ny;
      if (wsq < 0) wsq = 0;
      av = floor_sqrt(wsq);
      ang = turn_atan2(av * 16384, -ny * 16384);
      sa = ang;
      if (ang > 32'h8000_0000) sa = sa - (64'sd1 << 32);
      if (sa < -(64'sd1 << 30)) sa = sa + (64'sd1 << 32);
      if (sa < 0) sa = 0;
      if (sa > (64'sd1 << 31)) sa = 64'sd1 << 31;
      o.v = 17'((sa + 16384) >> 15);
      o.hit = 1;
      o.distance = 32'(root);
      o.px = 32'(px); o.py = 32'(py); o.pz = 32'(pz);
      o.nx = 17'(nx); o.ny = 17'(ny); o.nz = 17'(nz);
      o.front = front;
      o.mat = sph.material_id;
      return o;
   endfunction

   function automatic real uniform(real lo, real hi);
      return lo + (hi - lo) * ($urandom / 4294967295.0);
   endfunction

   // ray starting near the sphere and pointing roughly at it
   function automatic ray_t aimed_ray();
      ray_t   r;
      real    span, o[3], v[3], n;
      longint c[3];
      c[0] = sph.center_x; c[1] = sph.center_y; c[2] = sph.center_z;
      span = real'(sph.radius);
      for (int i = 0; i < 3; i++) begin
         o[i] = real'(clamp32(c[i] + longint'(uniform(-4.0, 4.0) * span)));
         v[i] = real'(c[i]) + uniform(-1.3, 1.3) * span - o[i];
      end
      n = $sqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]);
      if (n < 1.0) begin
         v[0] = 1.0; v[1] = 0.0; v[2] = 0.0; n = 1.0;
      end
      r.origin_x = 32'(longint'(o[0]));
      r.origin_y = 32'(longint'(o[1]));
      r.origin_z = 32'(longint'(o[2]));
      r.dir_x = 17'(longint'(v[0] / n * 32768.0));
      r.dir_y = 17'(longint'(v[1] / n * 32768.0));
      r.dir_z = 17'(longint'(v[2] / n * 32768.0));
      case ($urandom_range(3))
         0: r.t_min = 0;
         1: r.t_min = -32'($urandom_range(1 << 20));
         2: r.t_min = $urandom;
         default: r.t_min = $urandom_range(1 << 16);
      endcase
      r.t_max = ($urandom_range(99) < 80) ? 32'h7FFF_FFFF : $urandom;
      return r;
   endfunction

   function automatic ray_t noise_ray();
      ray_t r;
      r.origin_x = $urandom; r.origin_y = $urandom; r.origin_z = $urandom;
      r.dir_x = 17'($urandom); r.dir_y = 17'($urandom); r.dir_z = 17'($urandom);
      r.t_min = $urandom; r.t_max = $urandom;
      return r;
   endfunction

   function automatic probe_t probe(longint ox, longint oy, longint oz, longint dx,
                                    longint dy, longint dz, longint tmin, longint tmax,
                                    bit miss);
      probe_t p;
      p.ray = '{32'(ox), 32'(oy), 32'(oz), 17'(dx), 17'(dy), 17'(dz), 32'(tmin), 32'(tmax)};
      p.known_miss = miss;
      return p;
   endfunction

   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endfunction

   task automatic set_idling(int mode);
      tx_gap_pct   = (mode == 1) ? 53 : (mode == 3) ? 29 : 0;
      rx_stall_pct = (mode == 2) ? 53 : (mode == 3) ? 29 : 0;
   endtask

   task automatic send_ray(ray_t r, bit known_miss);
      while ($urandom_range(99) < tx_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, r.t_max, r.t_min, r.dir_z, r.dir_y, r.dir_x,
                     r.origin_z, r.origin_y, r.origin_x};
      do @(posedge clock); while (!req_tready);
      hits_due.push_back(known_miss ? hit_rec_t'('0) : predict_hit(r));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (hits_due.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(int idx, logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 5'(4 * idx);
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_CENTER_X:   sph.center_x    = val;
         REG_CENTER_Y:   sph.center_y    = val;
         REG_CENTER_Z:   sph.center_z    = val;
         REG_RADIUS:     sph.radius      = val[30:0];
         REG_INV_RADIUS: sph.inv_radius  = val[30:0];
         REG_MATERIAL:   sph.material_id = val[15:0];
         default: ;
      endcase
   endtask

   task automatic load_sphere(longint cx, longint cy, longint cz, longint rad,
                              longint inv, longint mat);
      csr_write(REG_CENTER_X, 32'(cx));
      csr_write(REG_CENTER_Y, 32'(cy));
      csr_write(REG_CENTER_Z, 32'(cz));
      csr_write(REG_RADIUS, 32'(rad));
      csr_write(REG_INV_RADIUS, 32'(inv));
      csr_write(REG_MATERIAL, 32'(mat));
   endtask

   function automatic longint recip(longint rad);
      longint v;
      v = (64'sd1 << 32) / rad;
      return v > 64'h7FFF_FFFF ? 64'h7FFF_FFFF : (v < 1 ? 1 : v);
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (hits_due.size() == 0) begin
            $error("result beat with nothing expected");
            errors++;
         end else begin
            want_rec = hits_due.pop_front();
            got_rec  = {rsp_tuser, rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64],
                        rsp_tdata[127:96], rsp_tdata[144:128], rsp_tdata[161:145],
                        rsp_tdata[178:162], rsp_tdata[179], rsp_tdata[196:180],
                        rsp_tdata[213:197], rsp_tdata[229:214]};
            check_field("hit", want_rec.hit, got_rec.hit);
            check_field("distance", want_rec.distance, got_rec.distance);
            check_field("point_x", want_rec.px, got_rec.px);
            check_field("point_y", want_rec.py, got_rec.py);
            check_field("point_z", want_rec.pz, got_rec.pz);
            check_field("normal_x", want_rec.nx, got_rec.nx);
            check_field("normal_y", want_rec.ny, got_rec.ny);
            check_field("normal_z", want_rec.nz, got_rec.nz);
            check_field("front_face", want_rec.front, got_rec.front);
            check_field("tex_u", want_rec.u, got_rec.u);
            check_field("tex_v", want_rec.v, got_rec.v);
            check_field("hit_material", want_rec.mat, got_rec.mat);
         end
      end
   end

   initial begin
      probe_t probes[$];
      longint rad;
      errors = 0;
      cycles = 0;
      set_idling(0);
      sph = '{0, 0, 0, 31'd65536, 31'd65536, 16'd0};
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      rsp_tready  <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // unit sphere at the origin after reset
      probes.push_back(probe(0, 0, 0, 0, 0, 0, 0, 0, 1));
      probes.push_back(probe(0, 0, -3 * Q_ONE, 0, 0, 32768, 0, S32_MAX, 0));
      probes.push_back(probe(0, 0, -3 * Q_ONE, 0, 0, 32768, 3 * Q_ONE, S32_MAX, 0));
      probes.push_back(probe(0, 0, -3 * Q_ONE, 0, 0, 32768, 2 * Q_ONE, 2 * Q_ONE, 0));
      probes.push_back(probe(0, 0, -3 * Q_ONE, 0, 0, 32768,
                             2 * Q_ONE + 1, 2 * Q_ONE + 1, 1));
      probes.push_back(probe(0, 0, -3 * Q_ONE, 0, 0, 32768, 5 * Q_ONE, Q_ONE, 1));
      probes.push_back(probe(-5 * Q_ONE, Q_ONE, 0, 32768, 0, 0, S32_MIN, S32_MAX, 1));
      probes.push_back(probe(0, 0, 0, 32768, 0, 0, 0, S32_MAX, 0));
      probes.push_back(probe(3 * Q_ONE, 0, 0, -32768, 0, 0, S32_MIN, S32_MAX, 0));
      probes.push_back(probe(0, -3 * Q_ONE, 0, 0, 32768, 0, 0, S32_MAX, 0));
      probes.push_back(probe(0, 3 * Q_ONE, 0, 0, -32768, 0, 0, S32_MAX, 0));
      probes.push_back(probe(S32_MIN, S32_MIN, S32_MIN, 32768, 32768, 32768,
                             S32_MIN, S32_MAX, 0));
      probes.push_back(probe(S32_MAX, S32_MAX, S32_MAX, -65536, -65536, -65536,
                             S32_MIN, S32_MAX, 0));
      probes.push_back(probe(0, 0, 0, 65535, 65535, 65535, S32_MIN, S32_MIN, 0));
      probes.push_back(probe(Q_ONE / 2, 0, -Q_ONE / 2, 0, 0, 32768, S32_MIN, S32_MAX, 0));
      foreach (probes[i]) send_ray(probes[i].ray, probes[i].known_miss);
      drain();

      for (int ph = 1; ph <= 4; ph++) begin
         case (ph)
            1: begin
               load_sphere(3 * Q_ONE + Q_ONE / 2, -2 * Q_ONE, Q_ONE, 3 * Q_ONE / 2,
                           recip(3 * Q_ONE / 2), 16'h1234);
               csr_write(BAD_REG_IDX, $urandom);
            end
            2: load_sphere(S32_MAX, S32_MIN, 0, 64'h7FFF_FFFF, 2, 16'hFFFF);
            3: load_sphere(longint'($signed($urandom)) >>> 8, longint'($signed($urandom)) >>> 8,
                           longint'($signed($urandom)) >>> 8, 1, 64'h7FFF_FFFF, 0);
            default: begin
               rad = $urandom_range(1 << 22, 1 << 10);
               load_sphere(longint'($signed($urandom)) >>> 4, longint'($signed($urandom)) >>> 4,
                           longint'($signed($urandom)) >>> 4, rad, recip(rad) * 3,
                           $urandom_range(16'hFFFF));
            end
         endcase
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (i % 115 == 0) set_idling((i / 115 + ph) % 4);
            if (i == 200) drain();
            if ($urandom_range(99) < 80) send_ray(aimed_ray(), 0);
            else send_ray(noise_ray(), 0);
         end
         drain();
      end

      set_idling(0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ----- ray_sphere_intersect_core.f -----
+incdir+src
src/rsi_pkg.sv
src/rsi_disc.sv
src/rsi_root.sv
src/rsi_shade.sv
src/rsi_uv.sv
src/ray_sphere_intersect_core.sv
bench/tb.sv
